// ===== design/cscc_pkg.sv =====
// ----------------------------------------------------------------------------
// cscc_pkg: shared types and CRC functions for the config stream CRC checker
// Holds register indexes, item/config/step structs and the word-wide CRC math.
// ----------------------------------------------------------------------------
package cscc_pkg;

    localparam int WORD_WIDTH = 32;

    localparam logic [31:0] POLY32 = 32'h1EDC_6F41;
    localparam logic [15:0] POLY16 = 16'h8005;

    // configuration register indexes
    localparam logic [2:0] CFG_CRC_MODE        = 3'd0;
    localparam logic [2:0] CFG_CRC_REG_ADDR    = 3'd1;
    localparam logic [2:0] CFG_CMD_REG_ADDR    = 3'd2;
    localparam logic [2:0] CFG_RESET_CRC_CODE  = 3'd3;
    localparam logic [2:0] CFG_FRAME_DATA_ADDR = 3'd4;
    localparam logic [2:0] CFG_ADDR_BITS_USED  = 3'd5;
    localparam logic [2:0] CFG_AUTO_CRC_ENABLE = 3'd6;

    // result kinds
    localparam logic KIND_CRC_WRITE = 1'b0;
    localparam logic KIND_AUTO_CRC  = 1'b1;

    typedef struct packed {
        logic        crc_mode;
        logic [4:0]  crc_reg_addr;
        logic [4:0]  cmd_reg_addr;
        logic [31:0] reset_crc_code;
        logic [4:0]  frame_data_addr;
        logic [2:0]  addr_bits_used;
        logic        auto_crc_enable;
    } cfg_t;

    typedef struct packed {
        logic [4:0]            reg_address;
        logic [WORD_WIDTH-1:0] data_word;
        logic                  first_word;
        logic                  last_word;
    } item_t;

    typedef struct packed {
        logic [31:0] rem_next;
        logic        skip_next;
        logic        emit;
        logic [31:0] crc_value;
        logic        crc_kind;
    } step_t;

    // one serial CRC step, MSB-first register
    function automatic logic [31:0] crc_feed_bit(input logic [31:0] rem,
                                                 input logic din,
                                                 input logic mode);
        logic [31:0] r;
        logic        top;
        top = mode ? (rem[31] ^ din) : (rem[15] ^ din);
        if (mode)
        begin
            r = {rem[30:0], 1'b0} ^ (top ? POLY32 : 32'h0);
        end
        else
        begin
            r = {16'h0, rem[14:0], 1'b0} ^ {16'h0, (top ? POLY16 : 16'h0)};
        end
        return r;
    endfunction

    // whole word: data bits LSB first, then 4 or 5 address bits LSB first.
    // Linear in its inputs, so this flattens to an XOR matrix.
    function automatic logic [31:0] crc_feed_word(input logic [31:0] rem,
                                                  input logic [WORD_WIDTH-1:0] data,
                                                  input logic [4:0] addr,
                                                  input logic mode,
                                                  input logic use5);
        logic [31:0] r;
        r = rem;
        for (int i = 0; i < WORD_WIDTH; i++)
        begin
            r = crc_feed_bit(r, data[i], mode);
        end
        for (int i = 0; i < 4; i++)
        begin
            r = crc_feed_bit(r, addr[i], mode);
        end
        if (use5)
        begin
            r = crc_feed_bit(r, addr[4], mode);
        end
        return r;
    endfunction

    // bit-reversed remainder; 16-bit mode uses the low half only
    function automatic logic [31:0] crc_checksum(input logic [31:0] rem,
                                                 input logic mode);
        logic [31:0] v;
        v = '0;
        if (mode)
        begin
            for (int i = 0; i < 32; i++)
            begin
                v[31-i] = rem[i];
            end
        end
        else
        begin
            for (int i = 0; i < 16; i++)
            begin
                v[15-i] = rem[i];
            end
        end
        return v;
    endfunction

endpackage

// ===== design/cscc_step.sv =====
// ----------------------------------------------------------------------------
// cscc_step: per-word decision and CRC update
// Decides absorb / skip / clear / emit for one word and computes next state.
// ----------------------------------------------------------------------------
module cscc_step
    import cscc_pkg::*;
(
    input  cfg_t        cfg,
    input  item_t       item,
    input  logic [31:0] rem,
    input  logic        skip,
    output step_t       step
);

    logic [31:0] rem_absorbed;
    logic        use5;
    logic        hit_crc;
    logic        hit_reset;
    logic        hit_auto;

    assign use5         = (cfg.addr_bits_used > 3'd4);
    assign rem_absorbed = crc_feed_word(rem, item.data_word, item.reg_address,
                                        cfg.crc_mode, use5);
    assign hit_crc      = (item.reg_address == cfg.crc_reg_addr);
    assign hit_reset    = (item.reg_address == cfg.cmd_reg_addr) &&
                          (item.data_word == cfg.reset_crc_code);
    assign hit_auto     = item.last_word && cfg.auto_crc_enable &&
                          (item.reg_address == cfg.frame_data_addr);

    always_comb
    begin
        step.rem_next  = rem;
        step.skip_next = skip;
        step.emit      = 1'b0;
        step.crc_value = crc_checksum(rem, cfg.crc_mode);
        step.crc_kind  = KIND_CRC_WRITE;
        if (item.first_word && hit_crc)
        begin
            step.emit      = 1'b1;
            step.rem_next  = '0;
            step.skip_next = !item.last_word;
        end
        else if (item.first_word && hit_reset)
        begin
            step.rem_next  = '0;
            step.skip_next = !item.last_word;
        end
        else if (!item.first_word && skip)
        begin
            step.skip_next = !item.last_word;
        end
        else
        begin
            // ordinary word; a first word also closes any open skip
            step.skip_next = 1'b0;
            if (hit_auto)
            begin
                step.emit      = 1'b1;
                step.crc_value = crc_checksum(rem_absorbed, cfg.crc_mode);
                step.crc_kind  = KIND_AUTO_CRC;
                step.rem_next  = '0;
            end
            else
            begin
                step.rem_next = rem_absorbed;
            end
        end
    end

endmodule

// ===== design/config_stream_crc_checker.sv =====
// ----------------------------------------------------------------------------
// config_stream_crc_checker: CRC-16 / CRC-32C checker on config write words
// Folds ordinary write words into a running CRC and reports checksums.
// ----------------------------------------------------------------------------
//
//  channel   | direction | tdata                          | tuser       | tlast
//  ----------+-----------+--------------------------------+-------------+----------
//  s_*       | in        | [4:0] reg_address [36:5] data  | first_word  | last_word
//  m_*       | out       | [31:0] crc_value               | crc_kind    | -
//  cfg_*     | in        | cfg_wdata, index cfg_addr      | -           | -
//
//  Flow: a transaction is registered on acceptance; when it moves on, the
//  whole word (32 data bits plus 4/5 address bits) is folded into the CRC by
//  a flat XOR network; one transaction per cycle is sustained while the
//  result side is not stalled. A checksum passes the input register and
//  then the result register before m_tvalid rises.
//  Reset: rst_n clears valids, the remainder, the skip flag and loads the
//  register defaults. A stalled output holds its result; the input stage
//  still drains into it once m_tready rises, and s_tready follows that.
// ----------------------------------------------------------------------------
module config_stream_crc_checker
    import cscc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] reg_address, [36:5] data_word, zero pad
    input  logic [0:0]  s_tuser,   // [0] first_word
    input  logic        s_tlast,   // last_word
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] crc_value
    output logic [0:0]  m_tuser,   // [0] crc_kind
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    cfg_t        cfg_reg;
    item_t       item_reg;
    logic        in_valid_reg;
    logic [31:0] rem_reg;
    logic        skip_reg;
    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic        out_kind_reg;
    step_t       step;
    logic        advance;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_mode        <= 1'b1;
            cfg_reg.crc_reg_addr    <= 5'd0;
            cfg_reg.cmd_reg_addr    <= 5'd4;
            cfg_reg.reset_crc_code  <= 32'd7;
            cfg_reg.frame_data_addr <= 5'd2;
            cfg_reg.addr_bits_used  <= 3'd5;
            cfg_reg.auto_crc_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_CRC_MODE:        cfg_reg.crc_mode        <= cfg_wdata[0];
                CFG_CRC_REG_ADDR:    cfg_reg.crc_reg_addr    <= cfg_wdata[4:0];
                CFG_CMD_REG_ADDR:    cfg_reg.cmd_reg_addr    <= cfg_wdata[4:0];
                CFG_RESET_CRC_CODE:  cfg_reg.reset_crc_code  <= cfg_wdata;
                CFG_FRAME_DATA_ADDR: cfg_reg.frame_data_addr <= cfg_wdata[4:0];
                CFG_ADDR_BITS_USED:  cfg_reg.addr_bits_used  <= cfg_wdata[2:0];
                CFG_AUTO_CRC_ENABLE: cfg_reg.auto_crc_enable <= cfg_wdata[0];
                default:             ; // unused index: write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // The registered word moves on whenever the result slot is free or is
    // being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.reg_address <= s_tdata[4:0];
            item_reg.data_word   <= s_tdata[36:5];
            item_reg.first_word  <= s_tuser[0];
            item_reg.last_word   <= s_tlast;
        end
    end

    // ---------------- CRC step ----------------
    cscc_step u_step (
        .cfg  (cfg_reg),
        .item (item_reg),
        .rem  (rem_reg),
        .skip (skip_reg),
        .step (step)
    );

    // running state is committed only when the word actually moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            skip_reg <= 1'b0;
        end
        else if (advance)
        begin
            rem_reg  <= step.rem_next;
            skip_reg <= step.skip_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.emit)
        begin
            out_value_reg <= step.crc_value;
            out_kind_reg  <= step.crc_kind;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_kind_reg;

endmodule

// ===== tb/config_stream_crc_checker_tb.sv =====
// ----------------------------------------------------------------------------
// config_stream_crc_checker_tb: self-checking bench for the config CRC checker
// Streams decoded write words through the block under several register
// settings. A bit-serial CRC tracker predicts every checksum, and each result
// is compared in order. Stream sides idle at random except in the last phase.
// ----------------------------------------------------------------------------
module config_stream_crc_checker_tb
    import cscc_pkg::*;
();

    localparam logic [31:0] CRC32C_POLY    = 32'h1EDC_6F41;
    localparam logic [15:0] CRC16_POLY     = 16'h8005;
    localparam int          DRAIN_CYCLES   = 8;     // pipeline is two deep
    localparam int          PHASE_WORDS    = 256;
    localparam int          WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [31:0] value;
        logic        kind;
    } crc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    config_stream_crc_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // register copies, start at the reset defaults
    logic        cfg_mode       = 1'b1;
    logic [4:0]  cfg_crc_addr   = 5'd0;
    logic [4:0]  cfg_cmd_addr   = 5'd4;
    logic [31:0] cfg_reset_code = 32'd7;
    logic [4:0]  cfg_frame_addr = 5'd2;
    logic [2:0]  cfg_abits      = 3'd5;
    logic        cfg_auto       = 1'b0;

    // tracked CRC state
    logic [31:0] crc_state = '0;
    logic        skipping  = 1'b0;

    item_t       words_to_send[$];
    crc_result_t crc_expected[$];

    int          tx_idle_pct = 38;
    int          rx_idle_pct = 60;
    logic        in_taken    = 1'b0;
    int          stall_count = 0;
    int          mismatches  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // CRC tracker
    // ------------------------------------------------------------------------

    // one bit into an MSB-first register; 16-bit mode keeps the low half only
    function automatic logic [31:0] shift_in(input logic [31:0] r, input logic b,
                                             input logic wide);
        logic [31:0] s;
        logic        fb;
        s  = wide ? r : (r & 32'h0000_FFFF);
        fb = (wide ? s[31] : s[15]) ^ b;
        s  = s << 1;
        if (fb)
        begin
            s = s ^ (wide ? CRC32C_POLY : {16'h0, CRC16_POLY});
        end
        if (!wide)
        begin
            s = s & 32'h0000_FFFF;
        end
        return s;
    endfunction

    function automatic logic [31:0] reflect_crc(input logic [31:0] r, input logic wide);
        logic [31:0] v;
        int          n;
        v = '0;
        n = wide ? 32 : 16;
        for (int i = 0; i < n; i++)
        begin
            v[n-1-i] = r[i];
        end
        return v;
    endfunction

    task automatic track_word(input item_t w);
        crc_result_t r;
        int          nfold;
        nfold = (cfg_abits <= 3'd4) ? 4 : 5;
        if (w.first_word)
        begin
            // a first word always closes whatever packet was open
            skipping = 1'b0;
            if (w.reg_address == cfg_crc_addr)
            begin
                r.value = reflect_crc(crc_state, cfg_mode);
                r.kind  = KIND_CRC_WRITE;
                crc_expected.insert(crc_expected.size(), r);
                crc_state = '0;
                skipping  = !w.last_word;
                return;
            end
            if (w.reg_address == cfg_cmd_addr && w.data_word == cfg_reset_code)
            begin
                crc_state = '0;
                skipping  = !w.last_word;
                return;
            end
        end
        else if (skipping)
        begin
            if (w.last_word)
            begin
                skipping = 1'b0;
            end
            return;
        end
        for (int i = 0; i < 32; i++)
        begin
            crc_state = shift_in(crc_state, w.data_word[i], cfg_mode);
        end
        for (int i = 0; i < nfold; i++)
        begin
            crc_state = shift_in(crc_state, w.reg_address[i], cfg_mode);
        end
        if (w.last_word && cfg_auto && w.reg_address == cfg_frame_addr)
        begin
            r.value = reflect_crc(crc_state, cfg_mode);
            r.kind  = KIND_AUTO_CRC;
            crc_expected.insert(crc_expected.size(), r);
            crc_state = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: next word goes out at the falling edge once the last one is taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        item_t w;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (words_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                w = words_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, w.data_word, w.reg_address};
                s_tuser  <= w.first_word;
                s_tlast  <= w.last_word;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: track accepted words, check each result transaction in order
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        item_t       w;
        crc_result_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                w.reg_address = s_tdata[4:0];
                w.data_word   = s_tdata[36:5];
                w.first_word  = s_tuser[0];
                w.last_word   = s_tlast;
                track_word(w);
            end
            if (m_tvalid && m_tready)
            begin
                if (crc_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result: crc_value %08h crc_kind %0d",
                                 m_tdata, m_tuser[0]);
                    end
                end
                else
                begin
                    want = crc_expected.pop_front();
                    if (want.value !== m_tdata || want.kind !== m_tuser[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"mismatch: crc_value exp %08h got %08h, ",
                                      "crc_kind exp %0d got %0d"},
                                     want.value, m_tdata, want.kind, m_tuser[0]);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            begin
                stall_count <= 0;
            end
            else
            begin
                stall_count <= stall_count + 1;
            end
        end
    end

    initial
    begin : watchdog
        while (stall_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_word(input logic [4:0] a, input logic [31:0] d,
                                      input logic first, input logic last);
        item_t w;
        w.reg_address = a;
        w.data_word   = d;
        w.first_word  = first;
        w.last_word   = last;
        words_to_send.insert(words_to_send.size(), w);
    endfunction

    function automatic logic [31:0] rand_data();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // register write; only called while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CRC_MODE:        cfg_mode       = val[0];
            CFG_CRC_REG_ADDR:    cfg_crc_addr   = val[4:0];
            CFG_CMD_REG_ADDR:    cfg_cmd_addr   = val[4:0];
            CFG_RESET_CRC_CODE:  cfg_reset_code = val;
            CFG_FRAME_DATA_ADDR: cfg_frame_addr = val[4:0];
            CFG_ADDR_BITS_USED:  cfg_abits      = val[2:0];
            CFG_AUTO_CRC_ENABLE: cfg_auto       = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic mode, input logic [4:0] crc_a,
                              input logic [4:0] cmd_a, input logic [31:0] code,
                              input logic [4:0] frame_a, input logic [2:0] abits,
                              input logic auto_en);
        write_reg(CFG_CRC_MODE, {31'h0, mode});
        write_reg(CFG_CRC_REG_ADDR, {27'h0, crc_a});
        write_reg(CFG_CMD_REG_ADDR, {27'h0, cmd_a});
        write_reg(CFG_RESET_CRC_CODE, code);
        write_reg(CFG_FRAME_DATA_ADDR, {27'h0, frame_a});
        write_reg(CFG_ADDR_BITS_USED, {29'h0, abits});
        write_reg(CFG_AUTO_CRC_ENABLE, {31'h0, auto_en});
    endtask

    // hold off until every word is taken and every checksum is back, then let
    // the pipeline empty out words that produce no result
    task automatic drain();
        while (words_to_send.size() != 0 || s_tvalid || crc_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one packet of random shape; sent counts the words queued
    task automatic gen_packet(output int sent);
        int          sel;
        int          len;
        logic        cut;
        logic [4:0]  a;
        logic [31:0] d;
        sel = $urandom_range(99);
        len = $urandom_range(1, 5);
        cut = ($urandom_range(19) == 0);    // packet that never gets its last mark
        if (sel < 15)
        begin
            // CRC register write, trailing words are ignored
            for (int i = 0; i < len; i++)
            begin
                push_word(cfg_crc_addr, rand_data(), i == 0, i == len - 1);
            end
            sent = len;
        end
        else if (sel < 30)
        begin
            // reset command, sometimes with a wrong code; later words may match
            d = ($urandom_range(3) != 0) ? cfg_reset_code : rand_data();
            push_word(cfg_cmd_addr, d, 1'b1, len == 1);
            for (int i = 1; i < len; i++)
            begin
                push_word(cfg_cmd_addr, $urandom_range(1) ? cfg_reset_code : rand_data(),
                          1'b0, i == len - 1);
            end
            sent = len;
        end
        else if (sel < 85)
        begin
            // ordinary packet, half of them to the frame data register
            a = 5'($urandom_range(31));
            if ($urandom_range(1))
            begin
                a = cfg_frame_addr;
            end
            for (int i = 0; i < len; i++)
            begin
                push_word(a, rand_data(), i == 0, (i == len - 1) && !cut);
            end
            sent = len;
        end
        else
        begin
            // loose word with arbitrary marks
            a = 5'($urandom_range(31));
            push_word(a, rand_data(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            sent = 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          count;
        int          n;
        logic        paused;
        logic [4:0]  shared_a;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset defaults
        push_word(5'd0,  32'h0000_0000, 1'b1, 1'b1);   // checksum of an empty CRC
        push_word(5'd3,  32'hFFFF_FFFF, 1'b1, 1'b0);
        push_word(5'd3,  32'h0000_0000, 1'b0, 1'b0);
        push_word(5'd31, 32'h8000_0001, 1'b0, 1'b1);
        push_word(5'd0,  32'h1234_5678, 1'b1, 1'b0);   // CRC write, rest ignored
        push_word(5'd0,  32'hFFFF_FFFF, 1'b0, 1'b0);
        push_word(5'd4,  32'd7,         1'b0, 1'b1);
        push_word(5'd9,  32'hA5A5_A5A5, 1'b0, 1'b0);   // continuation without a start
        push_word(5'd4,  32'd7,         1'b1, 1'b0);   // reset command
        push_word(5'd4,  32'd7,         1'b0, 1'b1);
        push_word(5'd2,  32'hDEAD_BEEF, 1'b1, 1'b1);   // frame data, auto CRC off
        push_word(5'd4,  32'd8,         1'b1, 1'b0);   // wrong reset code
        push_word(5'd4,  32'd7,         1'b0, 1'b1);   // later match is absorbed
        push_word(5'd0,  32'h0000_0000, 1'b1, 1'b1);
        push_word(5'd0,  32'h0000_0001, 1'b1, 1'b0);   // skip left open...
        push_word(5'd17, 32'h0000_0001, 1'b1, 1'b1);   // ...closed by a new first word
        push_word(5'd0,  32'h0000_0000, 1'b1, 1'b1);
        push_word(5'd4,  32'd7,         1'b1, 1'b1);   // single-word reset command
        push_word(5'd16, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_word(5'd0,  32'h0000_0000, 1'b1, 1'b1);
        drain();

        // random phases; the remainder carries across each settings change
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_config(1'b1, 5'd0, 5'd4, 32'd7, 5'd2, 3'd5, 1'b1);
                1: set_config(1'b0, 5'd31, 5'd0, 32'h0000_0000, 5'd17, 3'd4, 1'b1);
                2: set_config(1'b1, 5'd9, 5'd9, 32'hFFFF_FFFF, 5'd9, 3'd7, 1'b1);
                3:
                begin
                    shared_a = 5'($urandom_range(31));
                    set_config(1'b0, shared_a + 5'd1, shared_a, $urandom, shared_a,
                               3'd0, 1'b1);
                end
                default:
                    set_config(1'($urandom_range(1)), 5'($urandom_range(31)),
                               5'($urandom_range(31)), $urandom,
                               5'($urandom_range(31)), 3'($urandom_range(7)),
                               1'($urandom_range(1)));
            endcase
            tx_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 60 : 0;
            rx_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 38 : 0;
            count  = 0;
            paused = 1'b0;
            while (count < PHASE_WORDS)
            begin
                gen_packet(n);
                count += n;
                // sender holds off mid-phase until every checksum is back
                if (ph == 1 && !paused && count >= PHASE_WORDS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                // keep the queue short so idling stays spread over the phase
                while (words_to_send.size() > 16)
                begin
                    @(posedge clk);
                end
            end
            drain();
        end

        mismatches += crc_expected.size();
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
